@@ hdl/bba_pkg.sv @@
// Shared types and constants for the buddy block allocator.
// Holds the transaction structs, status and kind codes, and the sequencer states.
// No dependencies.
`default_nettype none

package bba_pkg;

    // Fixed field widths of the request and response transactions
    localparam int REQ_BYTES_W = 20;
    localparam int OFF_W       = 19;
    localparam int ORDER_W     = 3;

    typedef enum logic
    {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [2:0]
    {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NO_SPACE  = 3'd3,
        ST_NOT_ALLOC = 3'd4
    } status_t;

    typedef struct packed
    {
        kind_t                  kind;
        logic [REQ_BYTES_W-1:0] request_bytes;
        logic [OFF_W-1:0]       free_offset;
    } req_t;

    typedef struct packed
    {
        status_t            status;
        logic [OFF_W-1:0]   block_offset;
        logic [ORDER_W-1:0] block_order;
    } rsp_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_REDUCE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_ORD,
        S_COMMIT,
        S_DELIVER
    } state_t;

    // Commands from the sequencer to the free-block search unit
    typedef struct packed
    {
        logic load;
        logic reduce;
        logic shift;
    } search_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/bba_search.sv @@
// Free-block search unit: one shared reduce/shift register over the page map.
// Reduces the free map one order per cycle, then scans it one word per cycle.
// Depends on bba_pkg.
`default_nettype none

module bba_search #(
    parameter int MAX_ORDER = 7,
    parameter int SCAN_LOG2 = 4
) (
    input  wire logic                     clk,
    input  wire bba_pkg::search_ctrl_t    ctrl,
    input  wire logic [(1<<MAX_ORDER)-1:0] busy,
    output logic                          hit,
    output logic [SCAN_LOG2-1:0]          hit_pos
);
    import bba_pkg::*;

    localparam int NUM_PAGES = 1 << MAX_ORDER;
    localparam int HALF      = NUM_PAGES / 2;
    localparam int SCAN_W    = 1 << SCAN_LOG2;

    logic [NUM_PAGES-1:0] vec_reg;
    logic [NUM_PAGES-1:0] vec_next;
    logic [SCAN_W-1:0]    word;

    // Load the inverted busy map, merge buddy pairs, or advance to the next word
    always_comb
    begin
        vec_next = vec_reg;
        if (ctrl.load)
        begin
            vec_next = ~busy;
        end
        else if (ctrl.reduce)
        begin
            vec_next = '0;
            for (int i = 0; i < HALF; i++)
            begin
                vec_next[i] = vec_reg[2*i] & vec_reg[2*i+1];
            end
        end
        else if (ctrl.shift)
        begin
            vec_next = vec_reg >> SCAN_W;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

    // Find the lowest free block in the current word
    assign word = vec_reg[SCAN_W-1:0];

    always_comb
    begin
        hit     = |word;
        hit_pos = '0;
        for (int i = SCAN_W - 1; i >= 0; i--)
        begin
            if (word[i])
            begin
                hit_pos = SCAN_LOG2'(i);
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/bba_order_mem.sv @@
// Block order store: one entry per page, written at the first page of a block.
// Single port, registered read data. Depends on bba_pkg.
`default_nettype none

module bba_order_mem #(
    parameter int ADDR_W = 7,
    parameter int DATA_W = 3
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0]      rd_data
);
    import bba_pkg::*;

    logic [DATA_W-1:0] mem [1<<ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    // Write the order of a new block
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/buddy_block_allocator.sv @@
// Buddy block allocator over 2^MAX_ORDER pages. Allocate loads the search register, makes
// k reduce passes (the block order), scans words of up to 16 blocks, then commits and delivers.
// Free checks the block-start flag, reads the order store (registered read), commits and delivers.
// One transaction at a time; a new request is taken while the last response waits.
// Reset clears the page map and block-start flags at once; no clearing pass.
// Depends on bba_pkg, bba_search and bba_order_mem.
`default_nettype none

module buddy_block_allocator #(
    parameter int POOL_LOG2 = 19,
    parameter int PAGE_LOG2 = 12,
    parameter int MAX_ORDER = 7
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire bba_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output bba_pkg::rsp_t      rsp
);
    import bba_pkg::*;

    localparam int NUM_PAGES = 1 << MAX_ORDER;
    localparam int ORD_W     = $clog2(MAX_ORDER + 1);
    localparam int SCAN_LOG2 = (MAX_ORDER < 4) ? MAX_ORDER : 4;
    localparam int WORD_W    = (MAX_ORDER > SCAN_LOG2) ? (MAX_ORDER - SCAN_LOG2) : 1;
    localparam logic [OFF_W-1:0] PAGE_LOW_MASK =
        (PAGE_LOG2 >= OFF_W) ? {OFF_W{1'b1}} : OFF_W'((1 << PAGE_LOG2) - 1);
    localparam logic [MAX_ORDER:0] NUM_PAGES_V = {1'b1, {MAX_ORDER{1'b0}}};

    state_t                 state_reg, state_next;
    kind_t                  kind_reg, kind_next;
    logic [ORD_W-1:0]       ord_reg, ord_next;
    logic [ORD_W-1:0]       lvl_reg, lvl_next;
    logic [WORD_W-1:0]      word_reg, word_next;
    logic [WORD_W-1:0]      last_word_reg, last_word_next;
    logic [MAX_ORDER-1:0]   first_reg, first_next;
    status_t                res_status_reg, res_status_next;
    logic [OFF_W-1:0]       res_off_reg, res_off_next;
    logic [ORDER_W-1:0]     res_ord_reg, res_ord_next;
    logic [NUM_PAGES-1:0]   busy_reg, busy_next;
    logic [NUM_PAGES-1:0]   start_reg, start_next;
    rsp_t                   rsp_reg, rsp_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    logic [REQ_BYTES_W-1:0] bytes_m1;
    logic [ORD_W-1:0]       req_ord;
    logic                   too_large;
    logic                   off_bad;
    logic [MAX_ORDER-1:0]   free_page;
    logic [MAX_ORDER:0]     nblk;
    logic [MAX_ORDER-1:0]   blk;
    logic [NUM_PAGES-1:0]   blk_mask;

    search_ctrl_t           ctrl;
    logic                   hit;
    logic [SCAN_LOG2-1:0]   hit_pos;
    logic                   mem_wr;
    logic                   mem_rd;
    logic [ORD_W-1:0]       mem_rdata;

    bba_search #(
        .MAX_ORDER (MAX_ORDER),
        .SCAN_LOG2 (SCAN_LOG2)
    ) u_search (
        .clk     (clk),
        .ctrl    (ctrl),
        .busy    (busy_reg),
        .hit     (hit),
        .hit_pos (hit_pos)
    );

    bba_order_mem #(
        .ADDR_W (MAX_ORDER),
        .DATA_W (ORD_W)
    ) u_order_mem (
        .clk     (clk),
        .wr_en   (mem_wr),
        .rd_en   (mem_rd),
        .addr    (first_reg),
        .wr_data (ord_reg),
        .rd_data (mem_rdata)
    );

    // Round the request up to a block order; 2^m < bytes holds when (bytes-1) >> m is nonzero
    assign bytes_m1  = req.request_bytes - REQ_BYTES_W'(1);
    assign too_large = (bytes_m1 >> POOL_LOG2) != '0;

    always_comb
    begin
        req_ord = '0;
        for (int k = 0; k < MAX_ORDER; k++)
        begin
            if ((bytes_m1 >> (PAGE_LOG2 + k)) != '0)
            begin
                req_ord = req_ord + ORD_W'(1);
            end
        end
    end

    // Free offset must be page aligned and inside the pool
    assign off_bad   = ((req.free_offset & PAGE_LOW_MASK) != '0) ||
                       ((req.free_offset >> (PAGE_LOG2 + MAX_ORDER)) != '0);
    assign free_page = MAX_ORDER'(req.free_offset >> PAGE_LOG2);

    // Number of blocks of the requested order in the pool
    assign nblk = NUM_PAGES_V >> req_ord;

    // Block index found by the scan, and the pages covered by the current block
    assign blk = MAX_ORDER'({word_reg, hit_pos});

    always_comb
    begin
        for (int j = 0; j < NUM_PAGES; j++)
        begin
            blk_mask[j] = ((MAX_ORDER'(j) ^ first_reg) >> ord_reg) == '0;
        end
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        ord_next        = ord_reg;
        lvl_next        = lvl_reg;
        word_next       = word_reg;
        last_word_next  = last_word_reg;
        first_next      = first_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_ord_next    = res_ord_reg;
        busy_next       = busy_reg;
        start_next      = start_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        ctrl            = '0;
        mem_wr          = 1'b0;
        mem_rd          = 1'b0;
        req_stall       = (state_reg != S_IDLE);

        // Drop the response once it is taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next    = req.kind;
                    res_off_next = '0;
                    res_ord_next = '0;
                    if (req.kind == KIND_ALLOC)
                    begin
                        if (req.request_bytes == '0)
                        begin
                            res_status_next = ST_ZERO;
                            state_next      = S_DELIVER;
                        end
                        else if (too_large)
                        begin
                            res_status_next = ST_TOO_LARGE;
                            state_next      = S_DELIVER;
                        end
                        else
                        begin
                            ord_next       = req_ord;
                            lvl_next       = '0;
                            word_next      = '0;
                            last_word_next = WORD_W'((nblk - 1'b1) >> SCAN_LOG2);
                            ctrl.load      = 1'b1;
                            state_next     = S_REDUCE;
                        end
                    end
                    else
                    begin
                        if (off_bad)
                        begin
                            res_status_next = ST_NOT_ALLOC;
                            state_next      = S_DELIVER;
                        end
                        else
                        begin
                            first_next = free_page;
                            state_next = S_FREE_RD;
                        end
                    end
                end
            end

            S_REDUCE:
            begin
                if (lvl_reg == ord_reg)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    ctrl.reduce = 1'b1;
                    lvl_next    = lvl_reg + ORD_W'(1);
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    first_next = blk << ord_reg;
                    state_next = S_COMMIT;
                end
                else if (word_reg == last_word_reg)
                begin
                    res_status_next = ST_NO_SPACE;
                    state_next      = S_DELIVER;
                end
                else
                begin
                    ctrl.shift = 1'b1;
                    word_next  = word_reg + WORD_W'(1);
                end
            end

            S_FREE_RD:
            begin
                if (!start_reg[first_reg])
                begin
                    res_status_next = ST_NOT_ALLOC;
                    state_next      = S_DELIVER;
                end
                else
                begin
                    mem_rd     = 1'b1;
                    state_next = S_FREE_ORD;
                end
            end

            S_FREE_ORD:
            begin
                ord_next   = (mem_rdata > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : mem_rdata;
                state_next = S_COMMIT;
            end

            S_COMMIT:
            begin
                if (kind_reg == KIND_ALLOC)
                begin
                    busy_next             = busy_reg | blk_mask;
                    start_next[first_reg] = 1'b1;
                    mem_wr                = 1'b1;
                end
                else
                begin
                    busy_next             = busy_reg & ~blk_mask;
                    start_next[first_reg] = 1'b0;
                end
                res_status_next = ST_OK;
                res_off_next    = OFF_W'(64'(first_reg) << PAGE_LOG2);
                res_ord_next    = ORDER_W'(ord_reg);
                state_next      = S_DELIVER;
            end

            S_DELIVER:
            begin
                // Hold until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status       = res_status_reg;
                    rsp_next.block_offset = res_off_reg;
                    rsp_next.block_order  = res_ord_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and allocation maps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            busy_reg      <= '0;
            start_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            busy_reg      <= busy_next;
            start_reg     <= start_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        ord_reg        <= ord_next;
        lvl_reg        <= lvl_next;
        word_reg       <= word_next;
        last_word_reg  <= last_word_next;
        first_reg      <= first_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_ord_reg    <= res_ord_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire
